// File: sv/binned_force_bias_accumulator_core_defines.svh
// Assertion macros shared by the checker of the bias accumulator.
// Depends on nothing; included by the checker file.
`ifndef BINNED_FORCE_BIAS_ACCUMULATOR_CORE_DEFINES_SVH
`define BINNED_FORCE_BIAS_ACCUMULATOR_CORE_DEFINES_SVH
`define BFBA_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define BFBA_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// File: sv/bfba_pkg.sv
// Package of the binned force bias accumulator: types and constants.
// Depends on nothing.
package bfba_pkg;
  localparam int unsigned DIMS_DEF = 2;
  localparam int unsigned BINS_DEF = 64;
  localparam int unsigned CFG_W = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned SUM_W = 48;
  localparam int unsigned CNT_W = 32;

  typedef enum logic [2:0] {
    REG_FIRST_LOWER = 3'd0,
    REG_FIRST_INV = 3'd1,
    REG_FIRST_BINS = 3'd2,
    REG_SECOND_LOWER = 3'd3,
    REG_SECOND_INV = 3'd4,
    REG_SECOND_BINS = 3'd5,
    REG_FULL = 3'd6,
    REG_MAXF = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] pos_first;
    logic signed [31:0] pos_second;
    logic signed [31:0] force_first;
    logic signed [31:0] force_second;
  } in_item_t;

  typedef struct packed {
    logic in_range;
    logic signed [31:0] bias_first;
    logic signed [31:0] bias_second;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] lower0;
    logic [31:0] inv0;
    logic [6:0] bins0;
    logic signed [31:0] lower1;
    logic [31:0] inv1;
    logic [6:0] bins1;
    logic [31:0] full;
    logic [17:0] maxf;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_WAIT, ST_UPD, ST_FDIV, ST_BQ, ST_BR,
    ST_BMUL, ST_BLO, ST_BFIN, ST_OUT
  } bk_state_t;

  typedef enum logic [1:0] {
    FR_IDLE, FR_MUL, FR_ADDR
  } fr_state_t;
endpackage

// File: sv/bfba_if.sv
// Valid/ready channel interface for the bias accumulator.
// Depends on nothing; payload type is a parameter.
interface bfba_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/bfba_ram.sv
// Generic single port RAM with registered read.
// Depends on nothing.
module bfba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: sv/bfba_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on nothing.
module bfba_divider #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic done,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);
  localparam int unsigned CW = $clog2(NW + 1);
  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0] r_r, r_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic busy_r, busy_nxt;
  logic [DW:0] sh;

  always_comb begin
    q_nxt = q_r;
    r_nxt = r_r;
    n_nxt = n_r;
    busy_nxt = busy_r;
    sh = {r_r[DW-1:0], q_r[NW-1]};
    if (start) begin
      q_nxt = num;
      r_nxt = '0;
      n_nxt = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt = {q_r[NW-2:0], 1'b0};
      if (sh >= {1'b0, den}) begin
        r_nxt = sh - {1'b0, den};
        q_nxt[0] = 1'b1;
      end else begin
        r_nxt = sh;
      end
      n_nxt = n_r - 1'b1;
      if (n_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      n_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      n_r <= n_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
  end

  assign done = busy_r && (n_r == CW'(1));
  assign quo = q_nxt;
  assign rem = r_nxt[DW-1:0];
endmodule

// File: sv/bfba_front.sv
// Front end: bins a position into a grid address and queues the work.
// Depends on bfba_pkg and bfba_if.
module bfba_front #(
  parameter int unsigned DIMS = bfba_pkg::DIMS_DEF,
  parameter int unsigned BINS = bfba_pkg::BINS_DEF,
  parameter int unsigned AW = 2 * $clog2(BINS)
) (
  input  logic clk,
  input  logic rst_n,
  input  bfba_pkg::cfg_t cfg,
  bfba_if.sink in_ch,
  output logic q_valid,
  input  logic q_pop,
  output logic q_range,
  output logic [AW-1:0] q_addr,
  output logic signed [31:0] q_f0,
  output logic signed [31:0] q_f1
);
  localparam int unsigned BW = $clog2(BINS + 1);
  localparam int unsigned DEPTH = BINS * BINS;
  localparam int unsigned QD = 2;
  localparam int unsigned ENT_W = 1 + AW + 64;

  bfba_pkg::fr_state_t st_r, st_nxt;
  bfba_pkg::in_item_t item_r, item_nxt;
  logic [63:0] t0_r, t0_nxt, t1_r, t1_nxt;
  logic neg0_r, neg0_nxt, neg1_r, neg1_nxt;
  logic [ENT_W-1:0] q_mem_r [QD];
  logic q_wp_r, q_rp_r;
  logic [1:0] q_cnt_r;
  logic push;
  logic [ENT_W-1:0] push_ent;
  logic signed [32:0] d0, d1;
  logic [BW-1:0] eb0, eb1;
  logic ok0, ok1, ok;
  logic [BW-1:0] i0, i1;
  logic [2*BW-1:0] addr_w;
  logic [AW-1:0] addr_c;

  function automatic logic [BW-1:0] eff_bins(input logic [6:0] b);
    logic [BW-1:0] r;
    if (b == 7'd0) begin
      r = BW'(1);
    end else if ({25'd0, b} > BINS) begin
      r = BW'(BINS);
    end else begin
      r = BW'(b);
    end
    return r;
  endfunction

  assign eb0 = eff_bins(cfg.bins0);
  assign eb1 = eff_bins(cfg.bins1);
  assign d0 = 33'(item_r.pos_first) - 33'(cfg.lower0);
  assign d1 = 33'(item_r.pos_second) - 33'(cfg.lower1);
  assign in_ch.ready = (st_r == bfba_pkg::FR_IDLE);

  always_comb begin
    ok0 = !neg0_r && (t0_r <= {32'(eb0), 32'd0});
    ok1 = (DIMS < 2) || (!neg1_r && (t1_r <= {32'(eb1), 32'd0}));
    ok = ok0 && ok1;
    i0 = (t0_r[63:32] >= 32'(eb0)) ? eb0 - 1'b1 : BW'(t0_r[63:32]);
    i1 = (t1_r[63:32] >= 32'(eb1)) ? eb1 - 1'b1 : BW'(t1_r[63:32]);
    if (DIMS < 2) begin
      i1 = '0;
    end
    addr_w = (2*BW)'(i0) + (2*BW)'(i1) * (2*BW)'(eb0);
    addr_c = (addr_w >= (2*BW)'(DEPTH)) ? AW'(DEPTH - 1) : AW'(addr_w);
    push_ent = {ok, addr_c, item_r.force_first, item_r.force_second};
  end

  always_comb begin
    st_nxt = st_r;
    item_nxt = item_r;
    t0_nxt = t0_r;
    t1_nxt = t1_r;
    neg0_nxt = neg0_r;
    neg1_nxt = neg1_r;
    push = 1'b0;
    unique case (st_r)
      bfba_pkg::FR_IDLE: begin
        if (in_ch.valid) begin
          item_nxt = in_ch.data;
          st_nxt = bfba_pkg::FR_MUL;
        end
      end
      bfba_pkg::FR_MUL: begin
        neg0_nxt = d0[32];
        neg1_nxt = d1[32];
        t0_nxt = 64'(d0[31:0]) * 64'(cfg.inv0);
        t1_nxt = 64'(d1[31:0]) * 64'(cfg.inv1);
        st_nxt = bfba_pkg::FR_ADDR;
      end
      bfba_pkg::FR_ADDR: begin
        if (q_cnt_r != 2'(QD)) begin
          push = 1'b1;
          st_nxt = bfba_pkg::FR_IDLE;
        end
      end
      default: st_nxt = bfba_pkg::FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= bfba_pkg::FR_IDLE;
      q_wp_r <= 1'b0;
      q_rp_r <= 1'b0;
      q_cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (push) begin
        q_wp_r <= ~q_wp_r;
      end
      if (q_pop) begin
        q_rp_r <= ~q_rp_r;
      end
      q_cnt_r <= q_cnt_r + 2'(push) - 2'(q_pop);
    end
    item_r <= item_nxt;
    t0_r <= t0_nxt;
    t1_r <= t1_nxt;
    neg0_r <= neg0_nxt;
    neg1_r <= neg1_nxt;
    if (push) begin
      q_mem_r[q_wp_r] <= push_ent;
    end
  end

  assign q_valid = (q_cnt_r != 2'd0);
  assign {q_range, q_addr, q_f0, q_f1} = q_mem_r[q_rp_r];
endmodule

// File: sv/bfba_back.sv
// Back end: updates bin statistics and computes the bias with a shared divider.
// Depends on bfba_pkg, bfba_if, bfba_ram and bfba_divider.
module bfba_back #(
  parameter int unsigned DIMS = bfba_pkg::DIMS_DEF,
  parameter int unsigned BINS = bfba_pkg::BINS_DEF,
  parameter int unsigned AW = 2 * $clog2(BINS)
) (
  input  logic clk,
  input  logic rst_n,
  input  bfba_pkg::cfg_t cfg,
  input  logic q_valid,
  output logic q_pop,
  input  logic q_range,
  input  logic [AW-1:0] q_addr,
  input  logic signed [31:0] q_f0,
  input  logic signed [31:0] q_f1,
  bfba_if.source out_ch
);
  localparam int unsigned DEPTH = BINS * BINS;
  localparam int unsigned SW = bfba_pkg::SUM_W;
  localparam int unsigned CW = bfba_pkg::CNT_W;
  localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [63:0] CAP = 64'd1 << 48;
  localparam logic [63:0] ONE_Q16 = 64'd65536;

  bfba_pkg::bk_state_t st_r, st_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic signed [31:0] f0_r, f0_nxt, f1_r, f1_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic signed [SW-1:0] s0_r, s0_nxt, s1_r, s1_nxt;
  logic [17:0] fac_r, fac_nxt;
  logic dim_r, dim_nxt;
  logic [63:0] mag_r, mag_nxt, q_r, q_nxt;
  logic [CW-1:0] r_r, r_nxt;
  logic [41:0] ph_r, ph_nxt;
  logic [65:0] num_r, num_nxt;
  bfba_pkg::out_item_t res_r, res_nxt;
  logic ov_r, ov_nxt;
  logic ld_out;

  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [CW-1:0] c_wd, c_rd;
  logic [SW-1:0] s0_wd, s0_rd, s1_wd, s1_rd;

  logic dv_start, dv_done;
  logic [63:0] dv_num, dv_quo;
  logic [CW-1:0] dv_den, dv_rem;

  logic signed [SW:0] add0, add1;
  logic signed [SW-1:0] cur_sum;
  logic [41:0] hi_prod, lo_prod;
  logic [49:0] fr_prod;
  logic [CW-1:0] full_eff;
  logic [63:0] fin_num;
  logic [47:0] out_sh;
  logic [31:0] out_v;

  bfba_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_cnt (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(c_wd), .rdata(c_rd));
  bfba_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_s0 (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(s0_wd), .rdata(s0_rd));
  bfba_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_s1 (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(s1_wd), .rdata(s1_rd));

  bfba_divider #(.NW(64), .DW(CW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .num(dv_num), .den(dv_den),
    .done(dv_done), .quo(dv_quo), .rem(dv_rem));

  assign add0 = (SW+1)'($signed(s0_rd)) + (SW+1)'(f0_r);
  assign add1 = (SW+1)'($signed(s1_rd)) + (SW+1)'(f1_r);
  assign cur_sum = dim_r ? s1_r : s0_r;
  assign hi_prod = 42'(fac_r) * 42'(q_r[47:24]);
  assign lo_prod = 42'(fac_r) * 42'(q_r[23:0]);
  assign fr_prod = 50'(fac_r) * 50'(r_r);
  assign full_eff = (cfg.full == '0) ? CW'(1) : cfg.full;

  always_comb begin
    if (num_r > 66'(CAP)) begin
      fin_num = CAP;
    end else if ((num_r[63:0] + dv_quo) > CAP) begin
      fin_num = CAP;
    end else begin
      fin_num = num_r[63:0] + dv_quo;
    end
  end

  assign out_sh = fin_num[63:16];

  always_comb begin
    if (!cur_sum[SW-1]) begin
      out_v = (out_sh > 48'h80000000) ? 32'h80000000 : out_sh[31:0];
      if (cur_sum != '0) begin
        out_v = 32'd0 - out_v;
      end
    end else begin
      out_v = (out_sh > 48'h7FFFFFFF) ? 32'h7FFFFFFF : out_sh[31:0];
    end
  end

  always_comb begin
    st_nxt = st_r;
    clr_nxt = clr_r;
    addr_nxt = addr_r;
    f0_nxt = f0_r;
    f1_nxt = f1_r;
    cnt_nxt = cnt_r;
    s0_nxt = s0_r;
    s1_nxt = s1_r;
    fac_nxt = fac_r;
    dim_nxt = dim_r;
    mag_nxt = mag_r;
    q_nxt = q_r;
    r_nxt = r_r;
    ph_nxt = ph_r;
    num_nxt = num_r;
    res_nxt = res_r;
    ov_nxt = ov_r;
    ld_out = 1'b0;
    q_pop = 1'b0;
    ram_we = 1'b0;
    ram_addr = addr_r;
    c_wd = cnt_r;
    s0_wd = s0_r;
    s1_wd = s1_r;
    dv_start = 1'b0;
    dv_num = '0;
    dv_den = cnt_r;
    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end
    unique case (st_r)
      bfba_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        ram_addr = clr_r;
        c_wd = '0;
        s0_wd = '0;
        s1_wd = '0;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          st_nxt = bfba_pkg::ST_IDLE;
        end
      end
      bfba_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          addr_nxt = q_addr;
          f0_nxt = q_f0;
          f1_nxt = q_f1;
          if (q_range) begin
            st_nxt = bfba_pkg::ST_READ;
          end else begin
            res_nxt = '0;
            st_nxt = bfba_pkg::ST_OUT;
          end
        end
      end
      bfba_pkg::ST_READ: st_nxt = bfba_pkg::ST_WAIT;
      bfba_pkg::ST_WAIT: begin
        cnt_nxt = (c_rd == '1) ? c_rd : c_rd + CW'(1);
        s0_nxt = (add0 > (SW+1)'(SMAX)) ? SMAX :
                 (add0 < (SW+1)'(SMIN)) ? SMIN : add0[SW-1:0];
        s1_nxt = (DIMS < 2) ? s1_rd :
                 (add1 > (SW+1)'(SMAX)) ? SMAX :
                 (add1 < (SW+1)'(SMIN)) ? SMIN : add1[SW-1:0];
        st_nxt = bfba_pkg::ST_UPD;
      end
      bfba_pkg::ST_UPD: begin
        ram_we = 1'b1;
        dv_start = 1'b1;
        dv_num = {15'd0, cnt_r, 17'd0};
        dv_den = full_eff;
        st_nxt = bfba_pkg::ST_FDIV;
      end
      bfba_pkg::ST_FDIV: begin
        dv_den = full_eff;
        if (dv_done) begin
          if (dv_quo <= ONE_Q16) begin
            fac_nxt = '0;
          end else if ((dv_quo - ONE_Q16) > 64'(cfg.maxf)) begin
            fac_nxt = cfg.maxf;
          end else begin
            fac_nxt = 18'(dv_quo - ONE_Q16);
          end
          dim_nxt = 1'b0;
          mag_nxt = s0_r[SW-1] ? 64'(-65'(s0_r)) : 64'(s0_r);
          res_nxt.in_range = 1'b1;
          st_nxt = bfba_pkg::ST_BQ;
        end
      end
      bfba_pkg::ST_BQ: begin
        dv_start = 1'b1;
        dv_num = mag_r;
        st_nxt = bfba_pkg::ST_BR;
      end
      bfba_pkg::ST_BR: begin
        if (dv_done) begin
          q_nxt = dv_quo;
          r_nxt = dv_rem;
          st_nxt = bfba_pkg::ST_BMUL;
        end
      end
      bfba_pkg::ST_BMUL: begin
        ph_nxt = hi_prod;
        dv_start = 1'b1;
        dv_num = 64'(fr_prod);
        st_nxt = bfba_pkg::ST_BLO;
      end
      bfba_pkg::ST_BLO: begin
        num_nxt = {ph_r, 24'd0} + 66'(lo_prod);
        st_nxt = bfba_pkg::ST_BFIN;
      end
      bfba_pkg::ST_BFIN: begin
        if (dv_done) begin
          if (!dim_r) begin
            res_nxt.bias_first = out_v;
            if (DIMS >= 2) begin
              dim_nxt = 1'b1;
              mag_nxt = s1_r[SW-1] ? 64'(-65'(s1_r)) : 64'(s1_r);
              st_nxt = bfba_pkg::ST_BQ;
            end else begin
              res_nxt.bias_second = '0;
              st_nxt = bfba_pkg::ST_OUT;
            end
          end else begin
            res_nxt.bias_second = out_v;
            st_nxt = bfba_pkg::ST_OUT;
          end
        end
      end
      bfba_pkg::ST_OUT: begin
        if (!ov_r || out_ch.ready) begin
          ld_out = 1'b1;
          ov_nxt = 1'b1;
          st_nxt = bfba_pkg::ST_IDLE;
        end
      end
      default: st_nxt = bfba_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= bfba_pkg::ST_CLEAR;
      clr_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      clr_r <= clr_nxt;
      ov_r <= ov_nxt;
    end
    addr_r <= addr_nxt;
    f0_r <= f0_nxt;
    f1_r <= f1_nxt;
    cnt_r <= cnt_nxt;
    s0_r <= s0_nxt;
    s1_r <= s1_nxt;
    fac_r <= fac_nxt;
    dim_r <= dim_nxt;
    mag_r <= mag_nxt;
    q_r <= q_nxt;
    r_r <= r_nxt;
    ph_r <= ph_nxt;
    num_r <= num_nxt;
    res_r <= res_nxt;
    if (ld_out) begin
      out_ch.data <= res_r;
    end
  end

  assign out_ch.valid = ov_r;
endmodule

// File: sv/binned_force_bias_accumulator_core.sv
// Binned force bias accumulator: one result per request. An in-range request holds the
// back end through five divides on its one divider (factor, two quotients, two
// remainders) before its result is offered; an out-of-range request skips the divides
// and is answered with a zero result.
// After reset all BINS_PER_DIM squared entries of the bin stores are cleared before any
// request is processed; configuration returns to its reset values at once.
module binned_force_bias_accumulator_core #(
  parameter int unsigned DIMS = bfba_pkg::DIMS_DEF,
  parameter int unsigned BINS_PER_DIM = bfba_pkg::BINS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [bfba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfba_pkg::CFG_W-1:0] cfg_data,
  bfba_if.sink in_ch,
  bfba_if.source out_ch
);
  localparam int unsigned AW = 2 * $clog2(BINS_PER_DIM);
  bfba_pkg::cfg_t cfg_r;
  logic q_valid, q_pop, q_range;
  logic [AW-1:0] q_addr;
  logic signed [31:0] q_f0, q_f1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{lower0: '0, inv0: 32'd65536, bins0: 7'd64, lower1: '0,
                 inv1: 32'd65536, bins1: 7'd64, full: 32'd200, maxf: 18'd65536};
    end else if (cfg_we) begin
      unique case (bfba_pkg::reg_idx_t'(cfg_index))
        bfba_pkg::REG_FIRST_LOWER: cfg_r.lower0 <= cfg_data;
        bfba_pkg::REG_FIRST_INV: cfg_r.inv0 <= cfg_data;
        bfba_pkg::REG_FIRST_BINS: cfg_r.bins0 <= cfg_data[6:0];
        bfba_pkg::REG_SECOND_LOWER: cfg_r.lower1 <= cfg_data;
        bfba_pkg::REG_SECOND_INV: cfg_r.inv1 <= cfg_data;
        bfba_pkg::REG_SECOND_BINS: cfg_r.bins1 <= cfg_data[6:0];
        bfba_pkg::REG_FULL: cfg_r.full <= cfg_data;
        bfba_pkg::REG_MAXF: cfg_r.maxf <= cfg_data[17:0];
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  bfba_front #(.DIMS(DIMS), .BINS(BINS_PER_DIM), .AW(AW)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .in_ch(in_ch), .q_valid(q_valid),
    .q_pop(q_pop), .q_range(q_range), .q_addr(q_addr), .q_f0(q_f0), .q_f1(q_f1));

  bfba_back #(.DIMS(DIMS), .BINS(BINS_PER_DIM), .AW(AW)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .q_valid(q_valid), .q_pop(q_pop),
    .q_range(q_range), .q_addr(q_addr), .q_f0(q_f0), .q_f1(q_f1),
    .out_ch(out_ch));
endmodule

// File: sv/bfba_checker.sv
// Port-level checker for the bias accumulator, bound to the top level.
// Depends on bfba_pkg and the assertion macro header.
`include "binned_force_bias_accumulator_core_defines.svh"
module bfba_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input bfba_pkg::out_item_t out_data
);
  `BFBA_ASSERT_IMPL(a_zero_out, clk, rst_n, out_valid && !out_data.in_range, out_data.bias_first == '0 && out_data.bias_second == '0)
  `BFBA_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `BFBA_ASSERT_NEXT(a_gap, clk, rst_n, in_valid && in_ready, !in_ready)
endmodule

bind binned_force_bias_accumulator_core bfba_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));

// File: sim/tb.sv
// Self-checking testbench of binned_force_bias_accumulator_core: predicts each result of
// the binned force sums and the ramped bias, and compares it with the block's output.
// Depends on bfba_pkg, bfba_if and the core from the RTL sources.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = bfba_pkg::BINS_DEF * bfba_pkg::BINS_DEF;
  localparam longint CYCLE_LIMIT = 5000000;
  localparam longint SUM_HI = 64'sh7FFF_FFFF_FFFF;
  localparam longint SUM_LO = -64'sh8000_0000_0000;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [bfba_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bfba_pkg::CFG_W-1:0] cfg_data;

  bfba_if #(.T(bfba_pkg::in_item_t)) in_ch ();
  bfba_if #(.T(bfba_pkg::out_item_t)) out_ch ();

  binned_force_bias_accumulator_core u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #10 clk = ~clk;

  logic signed [31:0] lower_q [2];
  logic [31:0] inv_q [2];
  logic [6:0] bins_q [2];
  logic [31:0] full_q;
  logic [17:0] maxf_q;

  int unsigned visits [DEPTH];
  longint force_sum_a [DEPTH];
  longint force_sum_b [DEPTH];

  bfba_pkg::out_item_t expected_bias [$];
  int errors = 0;
  bit idle_on = 1'b1;
  longint cycles = 0;

  function automatic int unsigned bins_used(int d);
    int unsigned b;
    b = bins_q[d];
    if (b < 1) b = 1;
    if (b > bfba_pkg::BINS_DEF) b = bfba_pkg::BINS_DEF;
    return b;
  endfunction

  function automatic bit locate(int d, logic signed [31:0] x, output int unsigned idx);
    longint diff;
    longint unsigned t;
    longint unsigned lim;
    idx = 0;
    diff = longint'(x) - longint'(lower_q[d]);
    if (diff < 0) return 1'b0;
    t = longint'(diff) * longint'({32'd0, inv_q[d]});
    lim = longint'(bins_used(d)) << 32;
    if (t > lim) return 1'b0;
    idx = int'(t >> 32);
    if (idx >= bins_used(d)) idx = bins_used(d) - 1;
    return 1'b1;
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    longint s;
    s = a + b;
    if (s > SUM_HI) s = SUM_HI;
    if (s < SUM_LO) s = SUM_LO;
    return s;
  endfunction

  function automatic logic signed [31:0] ramped_bias(longint unsigned factor, longint sum,
                                                     longint unsigned count);
    longint unsigned cap;
    longint unsigned mag;
    longint unsigned q;
    longint unsigned r;
    longint unsigned num;
    longint unsigned mag_out;
    cap = 64'd1 << 48;
    mag = (sum < 0) ? longint'(-sum) : longint'(sum);
    q = mag / count;
    r = mag % count;
    if (q != 0 && factor > cap / q) begin
      num = cap;
    end else begin
      num = factor * q + (factor * r) / count;
      if (num > cap) num = cap;
    end
    mag_out = num >> 16;
    if (sum > 0) begin
      if (mag_out > 64'h8000_0000) mag_out = 64'h8000_0000;
      return -mag_out[31:0];
    end
    if (mag_out > 64'h7FFF_FFFF) mag_out = 64'h7FFF_FFFF;
    return mag_out[31:0];
  endfunction

  function automatic bfba_pkg::out_item_t accumulate_sample(bfba_pkg::in_item_t it);
    bfba_pkg::out_item_t res;
    int unsigned i0;
    int unsigned i1;
    int unsigned addr;
    longint unsigned count;
    longint unsigned full;
    longint unsigned ramp;
    longint unsigned factor;
    res = '0;
    if (!locate(0, it.pos_first, i0)) return res;
    if (!locate(1, it.pos_second, i1)) return res;
    addr = i0 + i1 * bins_used(0);
    if (addr >= DEPTH) addr = DEPTH - 1;
    count = visits[addr];
    if (count < 64'hFFFF_FFFF) count++;
    visits[addr] = count[31:0];
    full = (full_q == 0) ? 1 : full_q;
    ramp = (2 * count * 65536) / full;
    factor = (ramp > 65536) ? ramp - 65536 : 0;
    if (factor > maxf_q) factor = maxf_q;
    force_sum_a[addr] = sat_sum(force_sum_a[addr], longint'(it.force_first));
    force_sum_b[addr] = sat_sum(force_sum_b[addr], longint'(it.force_second));
    res.in_range = 1'b1;
    res.bias_first = ramped_bias(factor, force_sum_a[addr], count);
    res.bias_second = ramped_bias(factor, force_sum_b[addr], count);
    return res;
  endfunction

  task automatic program_grid(logic [31:0] lo0, logic [31:0] iw0, logic [31:0] nb0,
                              logic [31:0] lo1, logic [31:0] iw1, logic [31:0] nb1,
                              logic [31:0] full, logic [31:0] maxf);
    bfba_pkg::reg_idx_t r;
    logic [31:0] vals [8];
    vals = '{lo0, iw0, nb0, lo1, iw1, nb1, full, maxf};
    for (int k = 0; k < 8; k++) begin
      r = bfba_pkg::reg_idx_t'(k);
      cfg_we <= 1'b1;
      cfg_index <= r;
      cfg_data <= vals[k];
      case (r)
        bfba_pkg::REG_FIRST_LOWER: lower_q[0] = vals[k];
        bfba_pkg::REG_FIRST_INV: inv_q[0] = vals[k];
        bfba_pkg::REG_FIRST_BINS: bins_q[0] = vals[k][6:0];
        bfba_pkg::REG_SECOND_LOWER: lower_q[1] = vals[k];
        bfba_pkg::REG_SECOND_INV: inv_q[1] = vals[k];
        bfba_pkg::REG_SECOND_BINS: bins_q[1] = vals[k][6:0];
        bfba_pkg::REG_FULL: full_q = vals[k];
        bfba_pkg::REG_MAXF: maxf_q = vals[k][17:0];
        default: ;
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_request(bfba_pkg::in_item_t it);
    int gap;
    gap = idle_on ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    expected_bias.push_back(accumulate_sample(it));
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (expected_bias.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic signed [31:0] inside_coord(int d);
    longint span;
    longint room;
    room = 64'sh7FFF_FFFF - longint'(lower_q[d]);
    if (inv_q[d] == 0) span = room;
    else span = (longint'(bins_used(d)) << 32) / longint'({32'd0, inv_q[d]});
    if (span > room) span = room;
    case ($urandom_range(0, 9))
      0: return lower_q[d];
      1: return longint'(lower_q[d]) + span;
      default: return longint'(lower_q[d]) +
                      longint'({$urandom, $urandom} % longint'(span + 1));
    endcase
  endfunction

  function automatic bfba_pkg::in_item_t random_sample();
    bfba_pkg::in_item_t it;
    it.pos_first = $urandom;
    it.pos_second = $urandom;
    it.force_first = $urandom;
    it.force_second = $urandom;
    if ($urandom_range(0, 9) < 8) begin
      it.pos_first = inside_coord(0);
      it.pos_second = inside_coord(1);
      if ($urandom_range(0, 3) != 0) begin
        it.force_first = $signed(it.force_first) >>> $urandom_range(0, 24);
        it.force_second = $signed(it.force_second) >>> $urandom_range(0, 24);
      end
    end else if ($urandom_range(0, 1) == 1) begin
      it.pos_first = inside_coord(0);
      it.pos_second = lower_q[1] - 1;
    end
    return it;
  endfunction

  task automatic test_default_grid;
    logic signed [31:0] top;
    top = 32'sh0040_0000;
    send_request('{32'sd0, 32'sd0, 32'sh7FFF_FFFF, 32'sh8000_0000});
    send_request('{top, top, 32'sh0001_0000, -32'sh0001_0000});
    send_request('{top + 1, 32'sd5, 32'sd1, 32'sd1});
    send_request('{-32'sd1, 32'sd5, 32'sd1, 32'sd1});
    send_request('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd7, 32'sd7});
    send_request('{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd7, 32'sd7});
    send_request('{32'sh0001_8000, 32'sh0020_0000, 32'sd0, 32'sd0});
    drain();
  endtask

  task automatic test_bias_saturation;
    program_grid(32'h8000_0000, 32'h0000_0001, 32'd1, 32'h8000_0000, 32'h0000_0001, 32'd1,
                 32'd1, 32'h3FFFF);
    for (int k = 0; k < 6; k++)
      send_request('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF});
    drain();
    program_grid(32'h0000_0000, 32'h0000_0000, 32'd0, 32'h0010_0000, 32'hFFFF_FFFF,
                 32'd127, 32'd0, 32'h0);
    send_request('{32'sh7FFF_FFFF, 32'sh0010_0000, 32'sd100, -32'sd100});
    send_request('{32'sd0, 32'sh0010_0040, 32'sd100, -32'sd100});
    send_request('{32'sd3, 32'sh000F_FFFF, 32'sd100, -32'sd100});
    drain();
    program_grid(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd64, 32'h7FFF_FFFF, 32'h0001_0000,
                 32'd64, 32'hFFFF_FFFF, 32'h1_0000);
    send_request('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sd9, 32'sd9});
    drain();
  endtask

  task automatic test_random_phases;
    int pick;
    for (int p = 0; p < 7; p++) begin
      idle_on = (p != 2);
      pick = $urandom_range(0, 3);
      program_grid($urandom_range(0, 1) ? $urandom : -($urandom_range(0, 32'h0040_0000)),
                   (pick == 0) ? $urandom : (32'h0000_8000 << $urandom_range(0, 6)),
                   $urandom_range(1, 4) == 1 ? $urandom_range(1, 64) : $urandom_range(1, 4),
                   -($urandom_range(0, 32'h0010_0000)),
                   (pick == 1) ? $urandom : (32'h0001_0000 << $urandom_range(0, 4)),
                   $urandom_range(1, 4),
                   (p == 5) ? $urandom : $urandom_range(1, 80),
                   (p == 6) ? 32'h3FFFF : $urandom_range(0, 32'h3FFFF));
      for (int k = 0; k < 270; k++) send_request(random_sample());
      drain();
    end
  endtask

  initial begin
    forever begin
      int stall;
      stall = idle_on ? $urandom_range(0, 18) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_bias.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result %p", out_ch.data);
      end else begin
        bfba_pkg::out_item_t want;
        want = expected_bias.pop_front();
        if (out_ch.data.in_range !== want.in_range ||
            out_ch.data.bias_first !== want.bias_first ||
            out_ch.data.bias_second !== want.bias_second) begin
          errors++;
          if (errors <= 10)
            $display("Mismatch: expected %0d %0d %0d, got %0d %0d %0d", want.in_range,
                     want.bias_first, want.bias_second, out_ch.data.in_range,
                     out_ch.data.bias_first, out_ch.data.bias_second);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    lower_q = '{32'sd0, 32'sd0};
    inv_q = '{32'd65536, 32'd65536};
    bins_q = '{7'd64, 7'd64};
    full_q = 32'd200;
    maxf_q = 18'd65536;
    foreach (visits[k]) begin
      visits[k] = 0;
      force_sum_a[k] = 0;
      force_sum_b[k] = 0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_grid();
    test_bias_saturation();
    test_random_phases();
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_bias.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
